@@ sv/dtg_pkg.sv @@
// Shared types and constants for the dirty tile grid tracker.
// Used by dtg_ctrl, dtg_datapath and dirty_tile_grid_tracker; no dependencies.
`timescale 1ns / 1ps

package dtg_pkg;

    // Default geometry
    localparam int DEF_MAX_COLS = 32;
    localparam int DEF_MAX_ROWS = 64;
    localparam int DEF_TILE_W   = 32;
    localparam int DEF_TILE_H   = 8;

    // Copy commands kept per word; further runs are still processed
    localparam int MAX_RESULTS = 16;
    localparam int CNT_W       = $clog2(MAX_RESULTS + 1);
    localparam int IDX_W       = $clog2(MAX_RESULTS);

    // Field widths
    localparam int REGION_W = 13;
    localparam int ROW_IN_W = 6;
    localparam int FRAME_W  = 31;
    localparam int STAMP_W  = 32;
    localparam int POS_W    = 12;
    localparam int BOX_W    = 14;
    localparam int COLS_W   = 6;
    localparam int ROWS_W   = 7;

    // Signed width for pixel geometry compares (covers every legal tile size)
    localparam int CMP_W = 16;
    // Width for tile count compares (covers grid_rows and MAX_ROWS)
    localparam int GRID_CMP_W = 9;

    // Configuration port
    localparam int CFG_W     = 7;
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_COLS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS = 1'd1;
    localparam logic [COLS_W-1:0] GRID_COLS_RESET = 6'd32;
    localparam logic [ROWS_W-1:0] GRID_ROWS_RESET = 7'd64;

    // Item kinds
    localparam logic [1:0] KIND_CLEAR   = 2'd0;
    localparam logic [1:0] KIND_SAVE    = 2'd1;
    localparam logic [1:0] KIND_RESTORE = 2'd2;

    // Empty dirty box
    localparam logic signed [BOX_W-1:0] BOX_EMPTY_MIN = 14'sd8191;
    localparam logic signed [BOX_W-1:0] BOX_EMPTY_MAX = 14'sd0;

    // Controller to datapath commands
    typedef struct packed {
        logic capture;
        logic setup;
        logic walk;
        logic flush;
        logic emit_load;
    } dtg_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic walk_needed;
        logic walk_done;
        logic out_free;
        logic emit_last;
    } dtg_sts_t;

endpackage

@@ sv/dtg_ctrl.sv @@
// Sequencing state machine for the dirty tile grid tracker.
// Depends on dtg_pkg for the command and status structs.
`timescale 1ns / 1ps

module dtg_ctrl
    import dtg_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  dtg_sts_t sts,
    output dtg_cmd_t cmd
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SETUP = 3'd1;
    localparam logic [2:0] ST_WALK  = 3'd2;
    localparam logic [2:0] ST_FLUSH = 3'd3;
    localparam logic [2:0] ST_EMIT  = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    // Decode commands from the current state
    always_comb
    begin
        in_ready      = (state_reg == ST_IDLE);
        cmd.capture   = (state_reg == ST_IDLE) && in_valid;
        cmd.setup     = (state_reg == ST_SETUP);
        cmd.walk      = (state_reg == ST_WALK);
        cmd.flush     = (state_reg == ST_FLUSH);
        cmd.emit_load = (state_reg == ST_EMIT) && sts.out_free;
    end

    // Advance through setup, column walk, run flush and result emission
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                    state_next = ST_SETUP;
            end
            ST_SETUP:
            begin
                state_next = sts.walk_needed ? ST_WALK : ST_EMIT;
            end
            ST_WALK:
            begin
                if (sts.walk_done)
                    state_next = ST_FLUSH;
            end
            ST_FLUSH:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (sts.out_free && sts.emit_last)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

@@ sv/dtg_datapath.sv @@
// Datapath of the dirty tile grid tracker: stamp memory, row valid bits,
// run detection, dirty box, result buffer and output register. Uses dtg_pkg.
`timescale 1ns / 1ps

module dtg_datapath
    import dtg_pkg::*;
#(
    parameter int MAX_COLS = DEF_MAX_COLS,
    parameter int MAX_ROWS = DEF_MAX_ROWS,
    parameter int TILE_W   = DEF_TILE_W,
    parameter int TILE_H   = DEF_TILE_H
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [CFG_IDX_W-1:0]       cfg_index,
    input  logic [CFG_W-1:0]           cfg_data,
    input  logic [1:0]                 kind,
    input  logic signed [REGION_W-1:0] region_min_x,
    input  logic signed [REGION_W-1:0] region_max_x,
    input  logic signed [REGION_W-1:0] region_min_y,
    input  logic signed [REGION_W-1:0] region_max_y,
    input  logic [ROW_IN_W-1:0]        grid_row,
    input  logic [FRAME_W-1:0]         frame,
    input  logic signed [STAMP_W-1:0]  target_frame,
    input  logic                       first_row,
    input  dtg_cmd_t                   cmd,
    output dtg_sts_t                   sts,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic                       is_copy,
    output logic                       direction,
    output logic [POS_W-1:0]           pos_x,
    output logic [POS_W-1:0]           pos_y,
    output logic [POS_W-1:0]           run_width,
    output logic                       accepted,
    output logic signed [BOX_W-1:0]    box_min_x,
    output logic signed [BOX_W-1:0]    box_min_y,
    output logic signed [BOX_W-1:0]    box_max_x,
    output logic signed [BOX_W-1:0]    box_max_y,
    output logic                       last
);

    localparam int DEPTH  = MAX_ROWS * MAX_COLS;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int COL_W  = $clog2(MAX_COLS + 1);
    localparam int ROW_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

    localparam logic signed [CMP_W-1:0] ONE = CMP_W'(1);
    localparam logic signed [CMP_W-1:0] TW  = CMP_W'(TILE_W);
    localparam logic signed [CMP_W-1:0] TW2 = CMP_W'(2 * TILE_W);
    localparam logic signed [CMP_W-1:0] TH  = CMP_W'(TILE_H);
    localparam logic signed [CMP_W-1:0] TH2 = CMP_W'(2 * TILE_H);
    localparam logic [COL_W-1:0] COL_END  = COL_W'(MAX_COLS);
    localparam logic [COL_W-1:0] LAST_COL = COL_W'(MAX_COLS - 1);
    localparam logic [GRID_CMP_W-1:0] MAX_COLS_G = GRID_CMP_W'(MAX_COLS);
    localparam logic [GRID_CMP_W-1:0] MAX_ROWS_G = GRID_CMP_W'(MAX_ROWS);

    // Configuration
    logic [COLS_W-1:0] grid_cols_reg;
    logic [ROWS_W-1:0] grid_rows_reg;
    logic [GRID_CMP_W-1:0] eff_cols;
    logic [GRID_CMP_W-1:0] eff_rows;

    // Item registers
    logic [1:0]                 kind_reg;
    logic signed [REGION_W-1:0] rmin_x_reg;
    logic signed [REGION_W-1:0] rmax_x_reg;
    logic signed [REGION_W-1:0] rmin_y_reg;
    logic signed [REGION_W-1:0] rmax_y_reg;
    logic [ROW_IN_W-1:0]        row_reg;
    logic [FRAME_W-1:0]         stamp_reg;
    logic [STAMP_W-1:0]         target_reg;
    logic                       first_row_reg;
    logic signed [CMP_W-1:0]    py_reg;
    logic [ADDR_W-1:0]          row_base_reg;
    logic [STAMP_W-1:0]         target_in;

    // Setup terms
    logic is_save;
    logic is_rest;
    logic is_clear;
    logic signed [CMP_W-1:0] x0e;
    logic signed [CMP_W-1:0] y0e;
    logic signed [CMP_W-1:0] x0n;
    logic signed [CMP_W-1:0] x1n;
    logic signed [CMP_W-1:0] y0n;
    logic signed [CMP_W-1:0] y1n;
    logic reject;
    logic row_lt;
    logic y_lo_ok;
    logic y_hi_ok;
    logic [ROW_W-1:0] row_idx;
    logic signed [CMP_W-1:0] x0n_reg;
    logic signed [CMP_W-1:0] x1n_reg;
    logic acc_reg;
    logic rv_row_reg;
    logic [MAX_ROWS-1:0] rv_reg;

    // Dirty box
    logic signed [BOX_W-1:0] bmin_x_reg;
    logic signed [BOX_W-1:0] bmin_y_reg;
    logic signed [BOX_W-1:0] bmax_x_reg;
    logic signed [BOX_W-1:0] bmax_y_reg;
    logic signed [BOX_W-1:0] bmin_x_next;
    logic signed [BOX_W-1:0] bmin_y_next;
    logic signed [BOX_W-1:0] bmax_x_next;
    logic signed [BOX_W-1:0] bmax_y_next;
    logic signed [CMP_W-1:0] bmin_x_e;
    logic signed [CMP_W-1:0] bmin_y_e;
    logic signed [CMP_W-1:0] bmax_x_e;
    logic signed [CMP_W-1:0] bmax_y_e;

    // Walk: issue stage
    logic [COL_W-1:0]        iss_col_reg;
    logic signed [CMP_W-1:0] iss_px_reg;
    logic                    issue_go;
    logic                    iss_in;
    logic                    x_lo_ok;
    logic                    x_hi_ok;
    logic [ADDR_W-1:0]       rd_addr;

    // Walk: evaluate stage
    logic                    ev_valid_reg;
    logic [COL_W-1:0]        ev_col_reg;
    logic signed [CMP_W-1:0] ev_px_reg;
    logic                    ev_in_reg;
    logic [ADDR_W-1:0]       ev_addr_reg;
    logic [STAMP_W-1:0]      rdata_reg;
    logic [STAMP_W-1:0]      value;
    logic                    match;
    logic                    wr_en;
    logic [STAMP_W-1:0]      wr_data;
    logic [STAMP_W-1:0]      mem [DEPTH];

    // Runs and result buffer
    logic                    run_act_reg;
    logic signed [CMP_W-1:0] run_px_reg;
    logic signed [CMP_W-1:0] run_w_reg;
    logic                    close_run;
    logic signed [CMP_W-1:0] run_end;
    logic signed [CMP_W-1:0] py_end;
    logic [CNT_W-1:0]        cnt_reg;
    logic [IDX_W-1:0]        emit_idx_reg;
    logic [POS_W-1:0]        buf_px [MAX_RESULTS];
    logic [POS_W-1:0]        buf_w  [MAX_RESULTS];
    logic                    emit_last;
    logic                    out_valid_reg;

    // Hold configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_cols_reg <= GRID_COLS_RESET;
            grid_rows_reg <= GRID_ROWS_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_GRID_COLS: grid_cols_reg <= cfg_data[COLS_W-1:0];
                REG_GRID_ROWS: grid_rows_reg <= cfg_data[ROWS_W-1:0];
                default:       grid_cols_reg <= grid_cols_reg;
            endcase
        end
    end

    // Limit grid size to the store geometry
    always_comb
    begin
        eff_cols = (GRID_CMP_W'(grid_cols_reg) > MAX_COLS_G) ? MAX_COLS_G
                                                            : GRID_CMP_W'(grid_cols_reg);
        eff_rows = (GRID_CMP_W'(grid_rows_reg) > MAX_ROWS_G) ? MAX_ROWS_G
                                                            : GRID_CMP_W'(grid_rows_reg);
    end

    // Resolve negative target to frame minus one
    assign target_in = target_frame[STAMP_W-1] ? ({1'b0, frame} - STAMP_W'(1))
                                                : STAMP_W'(target_frame);

    // Capture the input word
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            kind_reg      <= kind;
            rmin_x_reg    <= region_min_x;
            rmax_x_reg    <= region_max_x;
            rmin_y_reg    <= region_min_y;
            rmax_y_reg    <= region_max_y;
            row_reg       <= grid_row;
            stamp_reg     <= frame;
            target_reg    <= target_in;
            first_row_reg <= first_row;
            py_reg        <= CMP_W'(grid_row * TILE_H);
            row_base_reg  <= ADDR_W'(grid_row * MAX_COLS);
        end
    end

    // Grow the save region and check the row against it
    always_comb
    begin
        is_save  = (kind_reg == KIND_SAVE);
        is_rest  = (kind_reg == KIND_RESTORE);
        is_clear = (kind_reg == KIND_CLEAR);
        x0e      = CMP_W'(rmin_x_reg);
        y0e      = CMP_W'(rmin_y_reg);
        x0n      = (x0e > 0) ? x0e - ONE : x0e;
        y0n      = (y0e > 0) ? y0e - ONE : y0e;
        x1n      = CMP_W'(rmax_x_reg) + ONE;
        y1n      = CMP_W'(rmax_y_reg) + ONE;
        reject   = (x0n >= x1n) || (y0n >= y1n);
        row_lt   = GRID_CMP_W'(row_reg) < eff_rows;
        y_lo_ok  = (y0n < 0) || (py_reg + TH > y0n);
        y_hi_ok  = (y1n >= 0) ? (py_reg - TH <= y1n) : (py_reg - TH2 < y1n);
        row_idx  = ROW_W'(row_reg);
    end

    assign sts.walk_needed = (is_save && !reject && row_lt && y_lo_ok && y_hi_ok)
                             || (is_rest && row_lt);

    // Hold per-item setup results
    always_ff @(posedge clk)
    begin
        if (cmd.setup)
        begin
            x0n_reg    <= x0n;
            x1n_reg    <= x1n;
            rv_row_reg <= rv_reg[row_idx];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            acc_reg <= 1'b1;
        else if (cmd.setup)
            acc_reg <= !(is_save && reject);
    end

    // Row valid bits: a row not yet written since clear reads as all zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rv_reg <= '0;
        else if (cmd.setup && is_clear)
            rv_reg <= '0;
        else if (cmd.flush && is_save)
            rv_reg[row_idx] <= 1'b1;
    end

    // Column range test for the issued column
    always_comb
    begin
        x_lo_ok  = (x0n_reg < 0) || (iss_px_reg + TW > x0n_reg);
        x_hi_ok  = (x1n_reg >= 0) ? (iss_px_reg - TW <= x1n_reg)
                                  : (iss_px_reg - TW2 < x1n_reg);
        iss_in   = (GRID_CMP_W'(iss_col_reg) < eff_cols)
                   && (!is_save || (x_lo_ok && x_hi_ok));
        issue_go = cmd.walk && (iss_col_reg < COL_END);
        rd_addr  = row_base_reg + ADDR_W'(iss_col_reg);
    end

    // Advance the issue column
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            iss_col_reg  <= '0;
            iss_px_reg   <= '0;
            ev_valid_reg <= 1'b0;
        end
        else if (cmd.setup)
        begin
            iss_col_reg  <= '0;
            iss_px_reg   <= '0;
            ev_valid_reg <= 1'b0;
        end
        else
        begin
            ev_valid_reg <= issue_go;
            if (issue_go)
            begin
                iss_col_reg <= iss_col_reg + COL_W'(1);
                iss_px_reg  <= iss_px_reg + TW;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue_go)
        begin
            ev_col_reg  <= iss_col_reg;
            ev_px_reg   <= iss_px_reg;
            ev_in_reg   <= iss_in;
            ev_addr_reg <= rd_addr;
        end
    end

    // Evaluate the stamp that came back from the store
    always_comb
    begin
        value         = rv_row_reg ? rdata_reg : '0;
        match         = ev_valid_reg && ev_in_reg
                        && (is_save ? (value == '0) : (value == target_reg));
        wr_en         = ev_valid_reg && is_save && (ev_in_reg || !rv_row_reg);
        wr_data       = ev_in_reg ? {1'b0, stamp_reg} : '0;
        sts.walk_done = ev_valid_reg && (ev_col_reg == LAST_COL);
        close_run     = run_act_reg && ((ev_valid_reg && !match) || cmd.flush);
        run_end       = run_px_reg + run_w_reg - ONE;
        py_end        = py_reg + TH - ONE;
    end

    // Stamp store: one read, one write port
    always_ff @(posedge clk)
    begin
        if (issue_go)
            rdata_reg <= mem[rd_addr];
        if (wr_en)
            mem[ev_addr_reg] <= wr_data;
    end

    // Track the current run of matching tiles
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            run_act_reg <= 1'b0;
        else if (cmd.setup || cmd.flush)
            run_act_reg <= 1'b0;
        else if (ev_valid_reg)
            run_act_reg <= match;
    end

    always_ff @(posedge clk)
    begin
        if (match)
        begin
            if (run_act_reg)
                run_w_reg <= run_w_reg + TW;
            else
            begin
                run_px_reg <= ev_px_reg;
                run_w_reg  <= TW;
            end
        end
    end

    // Push closed runs into the result buffer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else if (cmd.setup)
            cnt_reg <= '0;
        else if (close_run && (cnt_reg < CNT_W'(MAX_RESULTS)))
            cnt_reg <= cnt_reg + CNT_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (close_run && (cnt_reg < CNT_W'(MAX_RESULTS)))
        begin
            buf_px[cnt_reg[IDX_W-1:0]] <= run_px_reg[POS_W-1:0];
            buf_w[cnt_reg[IDX_W-1:0]]  <= run_w_reg[POS_W-1:0];
        end
    end

    // Widen or rebuild the dirty box
    always_comb
    begin
        bmin_x_e    = CMP_W'(bmin_x_reg);
        bmin_y_e    = CMP_W'(bmin_y_reg);
        bmax_x_e    = CMP_W'(bmax_x_reg);
        bmax_y_e    = CMP_W'(bmax_y_reg);
        bmin_x_next = bmin_x_reg;
        bmin_y_next = bmin_y_reg;
        bmax_x_next = bmax_x_reg;
        bmax_y_next = bmax_y_reg;
        if (cmd.setup && is_save && !reject)
        begin
            if (bmin_x_e > x0n) bmin_x_next = BOX_W'(x0n);
            if (bmin_y_e > y0n) bmin_y_next = BOX_W'(y0n);
            if (bmax_x_e < x1n) bmax_x_next = BOX_W'(x1n);
            if (bmax_y_e < y1n) bmax_y_next = BOX_W'(y1n);
        end
        else if (cmd.setup && is_rest && first_row_reg)
        begin
            bmin_x_next = BOX_EMPTY_MIN;
            bmin_y_next = BOX_EMPTY_MIN;
            bmax_x_next = BOX_EMPTY_MAX;
            bmax_y_next = BOX_EMPTY_MAX;
        end
        else if (close_run && is_rest)
        begin
            if (bmin_x_e > run_px_reg) bmin_x_next = BOX_W'(run_px_reg);
            if (bmin_y_e > py_reg)     bmin_y_next = BOX_W'(py_reg);
            if (bmax_x_e < run_end)    bmax_x_next = BOX_W'(run_end);
            if (bmax_y_e < py_end)     bmax_y_next = BOX_W'(py_end);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bmin_x_reg <= BOX_EMPTY_MIN;
            bmin_y_reg <= BOX_EMPTY_MIN;
            bmax_x_reg <= BOX_EMPTY_MAX;
            bmax_y_reg <= BOX_EMPTY_MAX;
        end
        else
        begin
            bmin_x_reg <= bmin_x_next;
            bmin_y_reg <= bmin_y_next;
            bmax_x_reg <= bmax_x_next;
            bmax_y_reg <= bmax_y_next;
        end
    end

    // Step through the buffered results
    assign emit_last     = (cnt_reg == '0)
                           || ((CNT_W'(emit_idx_reg) + CNT_W'(1)) == cnt_reg);
    assign sts.emit_last = emit_last;
    assign sts.out_free  = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            emit_idx_reg <= '0;
        else if (cmd.setup)
            emit_idx_reg <= '0;
        else if (cmd.emit_load)
            emit_idx_reg <= emit_idx_reg + IDX_W'(1);
    end

    // Output register: hold the word until the receiver takes it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.emit_load)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit_load)
        begin
            is_copy   <= (cnt_reg != '0);
            direction <= is_rest;
            pos_x     <= (cnt_reg != '0) ? buf_px[emit_idx_reg] : '0;
            pos_y     <= (cnt_reg != '0) ? py_reg[POS_W-1:0] : '0;
            run_width <= (cnt_reg != '0) ? buf_w[emit_idx_reg] : '0;
            accepted  <= acc_reg;
            box_min_x <= bmin_x_reg;
            box_min_y <= bmin_y_reg;
            box_max_x <= bmax_x_reg;
            box_max_y <= bmax_y_reg;
            last      <= emit_last;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

@@ sv/dirty_tile_grid_tracker.sv @@
// Top level of the dirty tile grid tracker: controller plus datapath.
// Depends on dtg_pkg, dtg_ctrl and dtg_datapath.
`timescale 1ns / 1ps

// Usage:
// - Input channel (in_valid/in_ready) takes one word per tile row: clear,
//   save of a region row, or restore of a row. Output channel
//   (out_valid/out_ready) returns one to MAX_RESULTS words per input word,
//   the final one marked by last.
// - Configuration (cfg_we/cfg_index/cfg_data) sets grid_cols and grid_rows;
//   write only while the block is idle.
// - Walk: a save or restore that touches a row walks every tile column of
//   the stamp memory, one column per cycle through its single read port,
//   then flushes the open run and emits its results. Clears, rejected
//   saves and rows out of range skip the walk and go straight to emission.
// - Reset clears all stamps at once through per-row valid bits; no clearing
//   pass is needed, and the first word is accepted right after reset.
// - A stalled receiver holds the output register; the walk result is kept
//   in a small buffer and emission pauses. The next input word is accepted
//   while the last result of the previous word still waits.

module dirty_tile_grid_tracker
    import dtg_pkg::*;
#(
    parameter int MAX_COLS = DEF_MAX_COLS,
    parameter int MAX_ROWS = DEF_MAX_ROWS,
    parameter int TILE_W   = DEF_TILE_W,
    parameter int TILE_H   = DEF_TILE_H
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [CFG_IDX_W-1:0]       cfg_index,
    input  logic [CFG_W-1:0]           cfg_data,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [1:0]                 kind,
    input  logic signed [REGION_W-1:0] region_min_x,
    input  logic signed [REGION_W-1:0] region_max_x,
    input  logic signed [REGION_W-1:0] region_min_y,
    input  logic signed [REGION_W-1:0] region_max_y,
    input  logic [ROW_IN_W-1:0]        grid_row,
    input  logic [FRAME_W-1:0]         frame,
    input  logic signed [STAMP_W-1:0]  target_frame,
    input  logic                       first_row,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic                       is_copy,
    output logic                       direction,
    output logic [POS_W-1:0]           pos_x,
    output logic [POS_W-1:0]           pos_y,
    output logic [POS_W-1:0]           run_width,
    output logic                       accepted,
    output logic signed [BOX_W-1:0]    box_min_x,
    output logic signed [BOX_W-1:0]    box_min_y,
    output logic signed [BOX_W-1:0]    box_max_x,
    output logic signed [BOX_W-1:0]    box_max_y,
    output logic                       last
);

    dtg_cmd_t cmd;
    dtg_sts_t sts;

    dtg_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    dtg_datapath #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS),
        .TILE_W   (TILE_W),
        .TILE_H   (TILE_H)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .kind         (kind),
        .region_min_x (region_min_x),
        .region_max_x (region_max_x),
        .region_min_y (region_min_y),
        .region_max_y (region_max_y),
        .grid_row     (grid_row),
        .frame        (frame),
        .target_frame (target_frame),
        .first_row    (first_row),
        .cmd          (cmd),
        .sts          (sts),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .is_copy      (is_copy),
        .direction    (direction),
        .pos_x        (pos_x),
        .pos_y        (pos_y),
        .run_width    (run_width),
        .accepted     (accepted),
        .box_min_x    (box_min_x),
        .box_min_y    (box_min_y),
        .box_max_x    (box_max_x),
        .box_max_y    (box_max_y),
        .last         (last)
    );

endmodule

@@ test/dirty_tile_grid_tracker_test.sv @@
// Self-checking testbench for dirty_tile_grid_tracker: directed and random row words
// checked against an in-bench tile stamp predictor. Depends on dtg_pkg and the block's RTL.
`timescale 1ns / 1ps

module dirty_tile_grid_tracker_test;
    import dtg_pkg::*;

    localparam int MAX_COLS     = DEF_MAX_COLS;
    localparam int MAX_ROWS     = DEF_MAX_ROWS;
    localparam int TILE_W       = DEF_TILE_W;
    localparam int TILE_H       = DEF_TILE_H;
    localparam int STALL_MAX    = 13;
    localparam int SHOWN_ERRORS = 10;
    localparam int TAIL_CYCLES  = MAX_COLS + 4 + MAX_RESULTS + 8;
    localparam int RUN_LIMIT_NS = 5_000_000;
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    typedef struct packed {
        logic [1:0]          kind;
        logic [REGION_W-1:0] min_x;
        logic [REGION_W-1:0] max_x;
        logic [REGION_W-1:0] min_y;
        logic [REGION_W-1:0] max_y;
        logic [ROW_IN_W-1:0] row;
        logic [FRAME_W-1:0]  frame;
        logic [STAMP_W-1:0]  target;
        logic                first_row;
    } row_word_t;

    typedef struct packed {
        logic             is_copy;
        logic             direction;
        logic [POS_W-1:0] pos_x;
        logic [POS_W-1:0] pos_y;
        logic [POS_W-1:0] run_width;
        logic             accepted;
        logic [BOX_W-1:0] box_min_x;
        logic [BOX_W-1:0] box_min_y;
        logic [BOX_W-1:0] box_max_x;
        logic [BOX_W-1:0] box_max_y;
        logic             last;
    } copy_cmd_t;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;
    logic                 in_valid;
    logic                 in_ready;
    logic [1:0]           kind;
    logic [REGION_W-1:0]  region_min_x;
    logic [REGION_W-1:0]  region_max_x;
    logic [REGION_W-1:0]  region_min_y;
    logic [REGION_W-1:0]  region_max_y;
    logic [ROW_IN_W-1:0]  grid_row;
    logic [FRAME_W-1:0]   frame;
    logic [STAMP_W-1:0]   target_frame;
    logic                 first_row;
    logic                 out_valid;
    logic                 out_ready;
    logic                 is_copy;
    logic                 direction;
    logic [POS_W-1:0]     pos_x;
    logic [POS_W-1:0]     pos_y;
    logic [POS_W-1:0]     run_width;
    logic                 accepted;
    logic [BOX_W-1:0]     box_min_x;
    logic [BOX_W-1:0]     box_min_y;
    logic [BOX_W-1:0]     box_max_x;
    logic [BOX_W-1:0]     box_max_y;
    logic                 last;

    // Predictor state: stamp store, dirty box and grid registers
    logic [STAMP_W-1:0] stamp_mirror [MAX_ROWS*MAX_COLS];
    int                 box_lo_x;
    int                 box_lo_y;
    int                 box_hi_x;
    int                 box_hi_y;
    logic [COLS_W-1:0]  cols_reg;
    logic [ROWS_W-1:0]  rows_reg;
    copy_cmd_t          cmds_due [$];

    int errors;
    bit quiet;
    int frame_no;

    dirty_tile_grid_tracker dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .kind         (kind),
        .region_min_x (region_min_x),
        .region_max_x (region_max_x),
        .region_min_y (region_min_y),
        .region_max_y (region_max_y),
        .grid_row     (grid_row),
        .frame        (frame),
        .target_frame (target_frame),
        .first_row    (first_row),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .is_copy      (is_copy),
        .direction    (direction),
        .pos_x        (pos_x),
        .pos_y        (pos_y),
        .run_width    (run_width),
        .accepted     (accepted),
        .box_min_x    (box_min_x),
        .box_min_y    (box_min_y),
        .box_max_x    (box_max_x),
        .box_max_y    (box_max_y),
        .last         (last)
    );

    // Clock: 12 ns period
    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // Build one copy command with the box left for the caller
    function automatic copy_cmd_t copy_run(input logic dir, input int px, input int py,
                                           input int wd);
        copy_cmd_t c;
        c = '0;
        c.is_copy   = 1'b1;
        c.direction = dir;
        c.pos_x     = POS_W'(px);
        c.pos_y     = POS_W'(py);
        c.run_width = POS_W'(wd);
        c.accepted  = 1'b1;
        return c;
    endfunction

    // Apply one accepted word to the mirror state and queue the results it causes
    function automatic void compute_copy_cmds(input row_word_t w);
        copy_cmd_t          runs [MAX_RESULTS];
        int                 n;
        int                 cols;
        int                 rows;
        int                 row;
        int                 x0;
        int                 x1;
        int                 y0;
        int                 y1;
        int                 gx0;
        int                 gx1;
        int                 gy0;
        int                 gy1;
        int                 c;
        int                 start;
        int                 len;
        int                 px;
        int                 py;
        int                 wd;
        int                 k;
        logic [STAMP_W-1:0] tgt;
        logic               dir;
        logic               acc;

        n    = 0;
        dir  = 1'b0;
        acc  = 1'b1;
        cols = (cols_reg > MAX_COLS) ? MAX_COLS : int'(cols_reg);
        rows = (rows_reg > MAX_ROWS) ? MAX_ROWS : int'(rows_reg);
        row  = int'(w.row);

        case (w.kind)
            KIND_CLEAR:
            begin
                for (k = 0; k < MAX_ROWS * MAX_COLS; k++)
                    stamp_mirror[k] = '0;
            end
            KIND_SAVE:
            begin
                x0 = $signed(w.min_x);
                x1 = $signed(w.max_x);
                y0 = $signed(w.min_y);
                y1 = $signed(w.max_y);
                // Grow the region by one pixel
                if (x0 > 0)
                    x0 = x0 - 1;
                x1 = x1 + 1;
                if (y0 > 0)
                    y0 = y0 - 1;
                y1 = y1 + 1;
                if (x0 >= x1 || y0 >= y1)
                    acc = 1'b0;
                else
                begin
                    if (box_lo_x > x0) box_lo_x = x0;
                    if (box_lo_y > y0) box_lo_y = y0;
                    if (box_hi_x < x1) box_hi_x = x1;
                    if (box_hi_y < y1) box_hi_y = y1;
                    // Tile span: clamp negative starts to 0, ends to the grid
                    gx0 = (x0 < 0) ? 0 : x0 / TILE_W;
                    gx1 = x1 / TILE_W + 2;
                    if (gx1 > cols)
                        gx1 = cols;
                    gy0 = (y0 < 0) ? 0 : y0 / TILE_H;
                    gy1 = y1 / TILE_H + 2;
                    if (gy1 > rows)
                        gy1 = rows;
                    if (row >= gy0 && row < gy1)
                    begin
                        c = gx0;
                        while (c < gx1)
                        begin
                            if (stamp_mirror[row*MAX_COLS + c] == '0)
                            begin
                                start = c;
                                len   = 0;
                                while (c < gx1 && stamp_mirror[row*MAX_COLS + c] == '0)
                                begin
                                    stamp_mirror[row*MAX_COLS + c] = {1'b0, w.frame};
                                    len++;
                                    c++;
                                end
                                if (n < MAX_RESULTS)
                                begin
                                    runs[n] = copy_run(1'b0, start * TILE_W, row * TILE_H,
                                                       len * TILE_W);
                                    n++;
                                end
                            end
                            else
                            begin
                                stamp_mirror[row*MAX_COLS + c] = {1'b0, w.frame};
                                c++;
                            end
                        end
                    end
                end
            end
            KIND_RESTORE:
            begin
                dir = 1'b1;
                // Negative target means the previous frame
                if (w.target[STAMP_W-1])
                    tgt = {1'b0, w.frame} - 32'd1;
                else
                    tgt = w.target;
                if (w.first_row)
                begin
                    box_lo_x = BOX_EMPTY_MIN;
                    box_lo_y = BOX_EMPTY_MIN;
                    box_hi_x = BOX_EMPTY_MAX;
                    box_hi_y = BOX_EMPTY_MAX;
                end
                if (row < rows)
                begin
                    c = 0;
                    while (c < cols)
                    begin
                        if (stamp_mirror[row*MAX_COLS + c] == tgt)
                        begin
                            start = c;
                            len   = 0;
                            while (c < cols && stamp_mirror[row*MAX_COLS + c] == tgt)
                            begin
                                len++;
                                c++;
                            end
                            px = start * TILE_W;
                            py = row * TILE_H;
                            wd = len * TILE_W;
                            if (box_lo_x > px) box_lo_x = px;
                            if (box_lo_y > py) box_lo_y = py;
                            if (box_hi_x < px + wd - 1) box_hi_x = px + wd - 1;
                            if (box_hi_y < py + TILE_H - 1) box_hi_y = py + TILE_H - 1;
                            if (n < MAX_RESULTS)
                            begin
                                runs[n] = copy_run(1'b1, px, py, wd);
                                n++;
                            end
                        end
                        else
                            c++;
                    end
                end
            end
            default:
            begin
            end
        endcase

        // No run: one status word
        if (n == 0)
        begin
            runs[0] = copy_run(dir, 0, 0, 0);
            runs[0].is_copy = 1'b0;
            n = 1;
        end
        for (k = 0; k < n; k++)
        begin
            runs[k].accepted  = acc;
            runs[k].box_min_x = BOX_W'(box_lo_x);
            runs[k].box_min_y = BOX_W'(box_lo_y);
            runs[k].box_max_x = BOX_W'(box_hi_x);
            runs[k].box_max_y = BOX_W'(box_hi_y);
            runs[k].last      = (k == n - 1);
            cmds_due.push_back(runs[k]);
        end
    endfunction

    function automatic row_word_t save_word(input int x0, input int x1, input int y0,
                                            input int y1, input int row,
                                            input logic [FRAME_W-1:0] f);
        row_word_t w;
        w = '0;
        w.kind   = KIND_SAVE;
        w.min_x  = REGION_W'(x0);
        w.max_x  = REGION_W'(x1);
        w.min_y  = REGION_W'(y0);
        w.max_y  = REGION_W'(y1);
        w.row    = ROW_IN_W'(row);
        w.frame  = f;
        w.target = STAMP_W'($urandom);
        return w;
    endfunction

    function automatic row_word_t restore_word(input int row, input logic [FRAME_W-1:0] f,
                                               input logic [STAMP_W-1:0] tgt,
                                               input logic first);
        row_word_t w;
        w = '0;
        w.kind      = KIND_RESTORE;
        w.min_x     = REGION_W'($urandom);
        w.max_y     = REGION_W'($urandom);
        w.row       = ROW_IN_W'(row);
        w.frame     = f;
        w.target    = tgt;
        w.first_row = first;
        return w;
    endfunction

    // Fully random word: any kind, any field value
    function automatic row_word_t noise_word();
        row_word_t w;
        w.kind      = 2'($urandom);
        w.min_x     = REGION_W'($urandom);
        w.max_x     = REGION_W'($urandom);
        w.min_y     = REGION_W'($urandom);
        w.max_y     = REGION_W'($urandom);
        w.row       = ROW_IN_W'($urandom);
        w.frame     = FRAME_W'($urandom);
        w.target    = STAMP_W'($urandom);
        w.first_row = 1'($urandom);
        return w;
    endfunction

    function automatic string show_cmd(input copy_cmd_t c);
        return $sformatf("copy=%0b dir=%0b x=%0d y=%0d w=%0d acc=%0b box=(%0d,%0d)..(%0d,%0d) last=%0b",
                         c.is_copy, c.direction, c.pos_x, c.pos_y, c.run_width, c.accepted,
                         $signed(c.box_min_x), $signed(c.box_min_y),
                         $signed(c.box_max_x), $signed(c.box_max_y), c.last);
    endfunction

    // Send one word; called and returns at a falling edge
    task automatic send_row(input row_word_t w);
        int gap;
        gap = 0;
        if (!quiet && $urandom_range(0, 4) == 0)
            gap = $urandom_range(1, STALL_MAX);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        kind         <= w.kind;
        region_min_x <= w.min_x;
        region_max_x <= w.max_x;
        region_min_y <= w.min_y;
        region_max_y <= w.max_y;
        grid_row     <= w.row;
        frame        <= w.frame;
        target_frame <= w.target;
        first_row    <= w.first_row;
        in_valid     <= 1'b1;
        // Hold until accepted, then predict
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        compute_copy_cmds(w);
        @(negedge clk);
    endtask

    // Drop valid and wait until every expected word has come back
    task automatic drain_results();
        in_valid <= 1'b0;
        @(negedge clk);
        while (cmds_due.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_grid(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        if (idx == REG_GRID_COLS)
            cols_reg = val[COLS_W-1:0];
        else
            rows_reg = val[ROWS_W-1:0];
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    // Episodes of saves followed by restores of the same rows, with some noise
    task automatic run_episodes(input int count);
        int                  sent;
        int                  saves;
        int                  k;
        int                  x0;
        int                  y0;
        int                  row;
        int                  rows_hit [4];
        logic [STAMP_W-1:0]  tgt;
        sent = 0;
        while (sent < count)
        begin
            if ($urandom_range(0, 9) < 7)
            begin
                frame_no++;
                saves = $urandom_range(1, 4);
                for (k = 0; k < saves; k++)
                begin
                    x0  = $urandom_range(0, 1100);
                    y0  = $urandom_range(0, 500);
                    row = y0 / TILE_H + $urandom_range(0, 2);
                    if (row > MAX_ROWS - 1)
                        row = MAX_ROWS - 1;
                    rows_hit[k] = row;
                    send_row(save_word(x0, x0 + $urandom_range(0, 400), y0,
                                       y0 + $urandom_range(0, 24), row, FRAME_W'(frame_no)));
                    sent++;
                end
                for (k = 0; k < saves; k++)
                begin
                    case ($urandom_range(0, 4))
                        0:       tgt = STAMP_W'(frame_no);
                        1:       tgt = '1;
                        2:       tgt = '0;
                        3:       tgt = STAMP_W'(frame_no - 1);
                        default: tgt = STAMP_W'($urandom);
                    endcase
                    send_row(restore_word(rows_hit[k], FRAME_W'(frame_no + 1), tgt, k == 0));
                    sent++;
                end
            end
            else
            begin
                send_row(noise_word());
                sent++;
            end
        end
    endtask

    // Restore of an untouched row after reset: one run over the whole row
    task automatic test_reset_state();
        send_row(restore_word(0, 1, 0, 1'b1));
    endtask

    // Saves: growth, partial runs, rejects, clamping, rows out of span, extremes
    task automatic test_save_region();
        send_row(save_word(0, 100, 0, 20, 1, 5));
        send_row(save_word(0, 300, 0, 20, 1, 6));
        send_row(save_word(10, 8, 0, 20, 1, 7));
        send_row(save_word(0, 50, 20, 10, 1, 7));
        send_row(save_word(4095, -4096, 4095, -4096, 2, 8));
        send_row(save_word(-50, -10, -30, -2, 0, 9));
        send_row(save_word(100, 120, 100, 120, 0, 10));
        send_row(save_word(-4096, 4095, -4096, 4095, 63, 31'h7FFF_FFFF));
        send_row(save_word(0, 31, 0, 7, 3, 0));
    endtask

    // Restores: exact and previous-frame targets, frame 0 wrap, inner rows and the bottom row
    task automatic test_restore();
        send_row(restore_word(1, 7, 6, 1'b1));
        send_row(restore_word(1, 7, 32'hFFFF_FFFF, 1'b0));
        send_row(restore_word(63, 0, 32'hFFFF_FFFF, 1'b1));
        send_row(restore_word(63, 1, 32'h7FFF_FFFF, 1'b0));
        send_row(restore_word(1, 3, 32'h8000_0000, 1'b0));
        send_row(restore_word(3, 9, 0, 1'b0));
    endtask

    // Unused kind leaves state alone; clear wipes every stamp but keeps the box
    task automatic test_clear_and_odd_kind();
        row_word_t w;
        w = '1;
        w.kind = KIND_UNUSED;
        send_row(w);
        w.kind = KIND_CLEAR;
        send_row(w);
        send_row(restore_word(1, 1, 0, 1'b1));
    endtask

    // Grid registers at the smallest, above maximum, zero, and back to reset
    task automatic test_config_extremes();
        drain_results();
        write_grid(REG_GRID_COLS, 7'd1);
        write_grid(REG_GRID_ROWS, 7'd1);
        send_row(save_word(-4096, 4095, -4096, 4095, 0, 20));
        send_row(restore_word(0, 21, 32'hFFFF_FFFF, 1'b1));
        send_row(restore_word(1, 21, 20, 1'b0));
        drain_results();
        write_grid(REG_GRID_COLS, 7'h7F);
        write_grid(REG_GRID_ROWS, 7'h7F);
        send_row(save_word(0, 2000, 0, 100, 5, 30));
        send_row(restore_word(5, 31, 32'hFFFF_FFFF, 1'b1));
        drain_results();
        write_grid(REG_GRID_COLS, 7'd0);
        write_grid(REG_GRID_ROWS, 7'd0);
        send_row(save_word(0, 100, 0, 20, 0, 40));
        send_row(restore_word(0, 41, 32'hFFFF_FFFF, 1'b1));
        drain_results();
        write_grid(REG_GRID_COLS, CFG_W'(MAX_COLS));
        write_grid(REG_GRID_ROWS, CFG_W'(MAX_ROWS));
    endtask

    // Random traffic under full, random and out-of-range grid settings
    task automatic test_random_traffic();
        int phase;
        for (phase = 0; phase < 3; phase++)
        begin
            drain_results();
            case (phase)
                0:
                begin
                    write_grid(REG_GRID_COLS, CFG_W'(MAX_COLS));
                    write_grid(REG_GRID_ROWS, CFG_W'(MAX_ROWS));
                end
                1:
                begin
                    write_grid(REG_GRID_COLS, CFG_W'($urandom_range(1, MAX_COLS)));
                    write_grid(REG_GRID_ROWS, CFG_W'($urandom_range(1, MAX_ROWS)));
                end
                default:
                begin
                    write_grid(REG_GRID_COLS, CFG_W'($urandom_range(0, 127)));
                    write_grid(REG_GRID_ROWS, CFG_W'($urandom_range(0, 127)));
                end
            endcase
            run_episodes(40);
        end
    endtask

    // Back-to-back traffic with no idling on either side
    task automatic test_steady_stream();
        drain_results();
        quiet = 1'b1;
        write_grid(REG_GRID_COLS, CFG_W'(MAX_COLS));
        write_grid(REG_GRID_ROWS, CFG_W'(MAX_ROWS));
        run_episodes(40);
    endtask

    // Receiver: random stall bursts unless quiet
    initial
    begin : receiver_stalls
        out_ready = 1'b1;
        forever
        begin
            @(negedge clk);
            if (!quiet && $urandom_range(0, 7) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, STALL_MAX)) @(negedge clk);
                out_ready <= 1'b1;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // Compare each accepted output word with the oldest expectation
    always @(posedge clk)
    begin : check_copy_cmds
        copy_cmd_t got;
        copy_cmd_t want;
        if (rst_n && out_valid && out_ready)
        begin
            got.is_copy   = is_copy;
            got.direction = direction;
            got.pos_x     = pos_x;
            got.pos_y     = pos_y;
            got.run_width = run_width;
            got.accepted  = accepted;
            got.box_min_x = box_min_x;
            got.box_min_y = box_min_y;
            got.box_max_x = box_max_x;
            got.box_max_y = box_max_y;
            got.last      = last;
            if (cmds_due.size() == 0)
            begin
                errors++;
                if (errors <= SHOWN_ERRORS)
                    $display("MISMATCH: unexpected word %s", show_cmd(got));
            end
            else
            begin
                want = cmds_due.pop_front();
                if (got.is_copy !== want.is_copy || got.direction !== want.direction ||
                    got.pos_x !== want.pos_x || got.pos_y !== want.pos_y ||
                    got.run_width !== want.run_width || got.accepted !== want.accepted ||
                    got.box_min_x !== want.box_min_x || got.box_min_y !== want.box_min_y ||
                    got.box_max_x !== want.box_max_x || got.box_max_y !== want.box_max_y ||
                    got.last !== want.last)
                begin
                    errors++;
                    if (errors <= SHOWN_ERRORS)
                        $display("MISMATCH: expected %s, actual %s", show_cmd(want),
                                 show_cmd(got));
                end
            end
        end
    end

    initial
    begin : watchdog
        #(RUN_LIMIT_NS);
        $display("DONE: errors detected");
        $finish;
    end

    initial
    begin : stimulus
        int k;
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = REG_GRID_COLS;
        cfg_data     = '0;
        in_valid     = 1'b0;
        kind         = KIND_CLEAR;
        region_min_x = '0;
        region_max_x = '0;
        region_min_y = '0;
        region_max_y = '0;
        grid_row     = '0;
        frame        = '0;
        target_frame = '0;
        first_row    = 1'b0;
        errors       = 0;
        quiet        = 1'b0;
        frame_no     = 100;
        // Mirror the reset state
        for (k = 0; k < MAX_ROWS * MAX_COLS; k++)
            stamp_mirror[k] = '0;
        box_lo_x = BOX_EMPTY_MIN;
        box_lo_y = BOX_EMPTY_MIN;
        box_hi_x = BOX_EMPTY_MAX;
        box_hi_y = BOX_EMPTY_MAX;
        cols_reg = GRID_COLS_RESET;
        rows_reg = GRID_ROWS_RESET;

        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_reset_state();
        test_save_region();
        test_restore();
        test_clear_and_odd_kind();
        test_config_extremes();
        test_random_traffic();
        test_steady_stream();

        // Let stray words show up before the verdict
        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (errors == 0 && cmds_due.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
